// ===== hw/rtl/csrcbs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csrcbs_pkg
// Shared field widths, request function codes and the queue status bundle
// for the CSR column block splitter.
// ---------------------------------------------------------------------------
package csrcbs_pkg;

   localparam int FUNC_W  = 2;
   localparam int BNUM_W  = 4;
   localparam int COL_W   = 24;
   localparam int SIZE_W  = 25;
   localparam int VALUE_W = 64;
   localparam int CSR_W   = 5;

   localparam logic [CSR_W-1:0] BLOCKS_RESET = 5'd16;

   localparam logic KIND_NONZERO = 1'b0;
   localparam logic KIND_ROW_PTR = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_NONZERO = 2'd1,
      FUNC_ROW_END = 2'd2,
      FUNC_CLEAR   = 2'd3
   } func_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== hw/rtl/csrcbs_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csrcbs_front
// Request stage: holds one request, loads the block table and classifies
// nonzeros against every block range in use before queueing them.
// ---------------------------------------------------------------------------
module csrcbs_front
   import csrcbs_pkg::*;
#(
   parameter int MAX_BLOCKS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [FUNC_W-1:0]                req_func,
   input  logic [BNUM_W-1:0]                req_block_number,
   input  logic [COL_W-1:0]                 req_block_start,
   input  logic [SIZE_W-1:0]                req_block_size,
   input  logic [COL_W-1:0]                 req_column,
   input  logic [VALUE_W-1:0]               req_entry_value,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]  n_active,
   input  q_stat_type                       q_stat,
   input  logic                             back_idle,
   output logic                             push,
   output logic [FUNC_W+MAX_BLOCKS+COL_W+VALUE_W-1:0] push_data,
   input  logic [$clog2(MAX_BLOCKS)-1:0]    rd_idx,
   output logic [COL_W-1:0]                 rd_start
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);

   logic                  full_ff, full_in;
   func_type              func_ff;
   logic [BNUM_W-1:0]     bnum_ff;
   logic [COL_W-1:0]      bstart_ff;
   logic [SIZE_W-1:0]     bsize_ff;
   logic [COL_W-1:0]      col_ff;
   logic [VALUE_W-1:0]    value_ff;

   logic [COL_W-1:0]      start_tab_ff [MAX_BLOCKS];
   logic [SIZE_W-1:0]     size_tab_ff  [MAX_BLOCKS];

   logic                  advance;
   logic                  accept;
   logic                  load_wr;
   logic [MAX_BLOCKS-1:0] hit;

   always_comb begin
      advance = full_ff && ((func_ff == FUNC_LOAD) ? (q_stat.empty && back_idle)
                                                   : !q_stat.full);
      busy    = full_ff && !advance;
      accept  = start && !busy;
      full_in = accept ? 1'b1 : (advance ? 1'b0 : full_ff);
      load_wr = advance && (func_ff == FUNC_LOAD) && (32'(bnum_ff) < MAX_BLOCKS);
      push    = advance && (func_ff != FUNC_LOAD);
   end

   always_comb begin
      logic [COL_W+1:0] hi;
      hit = '0;
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         hi = {2'b00, start_tab_ff[k]} + {1'b0, size_tab_ff[k]};
         hit[k] = (32'(n_active) > k) && (col_ff >= start_tab_ff[k])
                  && ({2'b00, col_ff} < hi);
      end
   end

   assign push_data = {func_ff, hit, col_ff, value_ff};
   assign rd_start  = start_tab_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= func_type'(req_func);
         bnum_ff   <= req_block_number;
         bstart_ff <= req_block_start;
         bsize_ff  <= req_block_size;
         col_ff    <= req_column;
         value_ff  <= req_entry_value;
      end
   end

   // sizes reset to empty ranges
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_BLOCKS; k++) begin
            size_tab_ff[k] <= '0;
         end
      end else if (load_wr) begin
         size_tab_ff[IDX_W'(bnum_ff)] <= bsize_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_wr) begin
         start_tab_ff[IDX_W'(bnum_ff)] <= bstart_ff;
      end
   end

endmodule

// ===== hw/rtl/csrcbs_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csrcbs_queue
// Four-entry request queue between the classifying stage and the emit stage.
// ---------------------------------------------------------------------------
module csrcbs_queue
   import csrcbs_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output q_stat_type       q_stat
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      q_stat.full  = (32'(count_ff) == DEPTH);
      q_stat.empty = (count_ff == '0);
      do_push      = push && !q_stat.full;
      do_pop       = pop && !q_stat.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in     = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   assign head = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/csrcbs_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csrcbs_back
// Emit stage: walks the matched blocks of a nonzero or every block in use for a row
// end, one response a cycle, and keeps the fill counts and the row counter.
// ---------------------------------------------------------------------------
module csrcbs_back
   import csrcbs_pkg::*;
#(
   parameter int MAX_BLOCKS = 16,
   parameter int INDEX_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]  n_active,
   input  q_stat_type                       q_stat,
   input  logic [FUNC_W+MAX_BLOCKS+COL_W+VALUE_W-1:0] head,
   output logic                             pop,
   output logic                             idle,
   output logic [$clog2(MAX_BLOCKS)-1:0]    rd_idx,
   input  logic [COL_W-1:0]                 rd_start,
   output logic                             rsp_valid,
   output logic                             rsp_kind,
   output logic [BNUM_W-1:0]                rsp_block_out,
   output logic [COL_W-1:0]                 rsp_local_column,
   output logic [COL_W-1:0]                 rsp_position,
   output logic [VALUE_W-1:0]               rsp_value_out,
   output logic [COL_W-1:0]                 rsp_row_number,
   output logic                             rsp_last
);

   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int ENTRY_W = FUNC_W + MAX_BLOCKS + COL_W + VALUE_W;
   localparam int WIDE_W  = (INDEX_BITS > COL_W) ? INDEX_BITS : COL_W;
   localparam int BLK_W   = (IDX_W > BNUM_W) ? IDX_W : BNUM_W;
   localparam logic [INDEX_BITS-1:0] COUNT_MAX = {INDEX_BITS{1'b1}};

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_ROUTE = 3'b010,
      S_ROW   = 3'b100
   } back_state_type;

   back_state_type         state_ff, state_in;
   logic [MAX_BLOCKS-1:0]  mask_ff, mask_in;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [INDEX_BITS-1:0]  fill_ff [MAX_BLOCKS];
   logic [INDEX_BITS-1:0]  fill_in [MAX_BLOCKS];
   logic [INDEX_BITS-1:0]  row_ff, row_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [BNUM_W-1:0]      rsp_block_ff, rsp_block_in;
   logic [COL_W-1:0]       rsp_local_ff, rsp_local_in;
   logic [COL_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [COL_W-1:0]       rsp_row_ff, rsp_row_in;
   logic                   rsp_last_ff, rsp_last_in;

   func_type               h_func;
   logic [MAX_BLOCKS-1:0]  h_mask;
   logic [COL_W-1:0]       h_col;
   logic [VALUE_W-1:0]     h_value;

   logic [IDX_W-1:0]       first;
   logic [IDX_W-1:0]       cur_idx;
   logic [MAX_BLOCKS-1:0]  mask_rest;
   logic                   row_last;
   logic [INDEX_BITS-1:0]  fill_cur;
   logic [INDEX_BITS-1:0]  fill_next;
   logic [INDEX_BITS-1:0]  row_next;
   logic [WIDE_W-1:0]      pos_wide;
   logic [WIDE_W-1:0]      row_wide;
   logic [BLK_W-1:0]       blk_wide;

   always_comb begin
      h_func  = func_type'(head[ENTRY_W-1 -: FUNC_W]);
      h_mask  = head[COL_W+VALUE_W +: MAX_BLOCKS];
      h_col   = head[VALUE_W +: COL_W];
      h_value = head[VALUE_W-1:0];
   end

   // lowest matched block first
   always_comb begin
      first = '0;
      for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            first = IDX_W'(k);
         end
      end
   end

   always_comb begin
      cur_idx   = (state_ff == S_ROW) ? cnt_ff : first;
      rd_idx    = cur_idx;
      mask_rest = mask_ff;
      mask_rest[first] = 1'b0;
      row_last  = ((32'(cnt_ff) + 32'd1) == 32'(n_active));
      fill_cur  = fill_ff[cur_idx];
      fill_next = (fill_cur == COUNT_MAX) ? fill_cur : fill_cur + INDEX_BITS'(1);
      row_next  = (row_ff == COUNT_MAX) ? row_ff : row_ff + INDEX_BITS'(1);
      pos_wide  = WIDE_W'(fill_cur);
      row_wide  = WIDE_W'(row_ff);
      blk_wide  = BLK_W'(cur_idx);
      pop       = (state_ff == S_IDLE) && !q_stat.empty;
      idle      = (state_ff == S_IDLE);
   end

   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      value_in     = value_ff;
      fill_in      = fill_ff;
      row_in       = row_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_NONZERO;
      rsp_block_in = blk_wide[BNUM_W-1:0];
      rsp_local_in = '0;
      rsp_pos_in   = pos_wide[COL_W-1:0];
      rsp_value_in = '0;
      rsp_row_in   = row_wide[COL_W-1:0];
      rsp_last_in  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               mask_in  = h_mask;
               cnt_in   = '0;
               col_in   = h_col;
               value_in = h_value;
               case (h_func)
                  FUNC_NONZERO: begin
                     if (h_mask != '0) begin
                        state_in = S_ROUTE;
                     end
                  end
                  FUNC_ROW_END: begin
                     if (n_active != '0) begin
                        state_in = S_ROW;
                     end else begin
                        row_in = row_next;
                     end
                  end
                  FUNC_CLEAR: begin
                     for (int k = 0; k < MAX_BLOCKS; k++) begin
                        fill_in[k] = '0;
                     end
                     row_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_ROUTE: begin
            rsp_valid_in     = 1'b1;
            rsp_kind_in      = KIND_NONZERO;
            rsp_local_in     = col_ff - rd_start;
            rsp_value_in     = value_ff;
            rsp_last_in      = (mask_rest == '0);
            fill_in[cur_idx] = fill_next;
            mask_in          = mask_rest;
            if (mask_rest == '0) begin
               state_in = S_IDLE;
            end
         end
         S_ROW: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_ROW_PTR;
            rsp_last_in  = row_last;
            cnt_in       = cnt_ff + IDX_W'(1);
            if (row_last) begin
               row_in   = row_next;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_BLOCKS; k++) begin
            fill_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff      <= mask_in;
      cnt_ff       <= cnt_in;
      col_ff       <= col_in;
      value_ff     <= value_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_block_ff <= rsp_block_in;
      rsp_local_ff <= rsp_local_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_block_out    = rsp_block_ff;
   assign rsp_local_column = rsp_local_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_value_out    = rsp_value_ff;
   assign rsp_row_number   = rsp_row_ff;
   assign rsp_last         = rsp_last_ff;

   a_route_has_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUTE |-> mask_ff != '0)
      else $error("route walk with no matched block left");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROW |-> 32'(cnt_ff) < 32'(n_active))
      else $error("row pointer walk past blocks in use");

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> state_ff == S_IDLE)
      else $error("final response while walk still active");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == S_IDLE || $past(h_func) == FUNC_NONZERO
              || $past(h_func) == FUNC_ROW_END)
      else $error("load or clear left the emit stage busy");

endmodule

// ===== hw/rtl/csr_column_block_split_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csr_column_block_split_core
// Splits a stream of CSR nonzeros into column blocks, routing each nonzero
// to every block range in use that holds it and reporting row pointers per block.
// ---------------------------------------------------------------------------
// Requests pass the request register, the queue and the emit stage.
// A nonzero gives one response per matching block (none with no match);
//   a row end gives one per block in use; a clear gives none.
//   A load waits until the queue and the emit stage have drained.
// Responses are strobed for one cycle each; the receiver cannot stall.
// Reset clears the block sizes, fill counts, row counter and queue and sets
//   blocks_in_use to 16; block starts stay undefined until loaded.
// ---------------------------------------------------------------------------
module csr_column_block_split_core
   import csrcbs_pkg::*;
#(
   parameter int MAX_BLOCKS = 16,
   parameter int INDEX_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CSR_W-1:0]   csr_wr_data,
   input  logic               start,
   output logic               busy,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [BNUM_W-1:0]  req_block_number,
   input  logic [COL_W-1:0]   req_block_start,
   input  logic [SIZE_W-1:0]  req_block_size,
   input  logic [COL_W-1:0]   req_column,
   input  logic [VALUE_W-1:0] req_entry_value,
   output logic               rsp_valid,
   output logic               rsp_kind,
   output logic [BNUM_W-1:0]  rsp_block_out,
   output logic [COL_W-1:0]   rsp_local_column,
   output logic [COL_W-1:0]   rsp_position,
   output logic [VALUE_W-1:0] rsp_value_out,
   output logic [COL_W-1:0]   rsp_row_number,
   output logic               rsp_last
);

   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int ENTRY_W = FUNC_W + MAX_BLOCKS + COL_W + VALUE_W;

   logic [CSR_W-1:0]   blocks_ff, blocks_in;
   logic [CNT_W-1:0]   n_active;
   q_stat_type         q_stat;
   logic               back_idle;
   logic               push;
   logic [ENTRY_W-1:0] push_data;
   logic               pop;
   logic [ENTRY_W-1:0] head;
   logic [IDX_W-1:0]   rd_idx;
   logic [COL_W-1:0]   rd_start;

   always_comb begin
      blocks_in = csr_wr_en ? csr_wr_data : blocks_ff;
      n_active  = (32'(blocks_ff) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(blocks_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_ff <= BLOCKS_RESET;
      end else begin
         blocks_ff <= blocks_in;
      end
   end

   csrcbs_front #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_block_number (req_block_number),
      .req_block_start  (req_block_start),
      .req_block_size   (req_block_size),
      .req_column       (req_column),
      .req_entry_value  (req_entry_value),
      .n_active         (n_active),
      .q_stat           (q_stat),
      .back_idle        (back_idle),
      .push             (push),
      .push_data        (push_data),
      .rd_idx           (rd_idx),
      .rd_start         (rd_start)
   );

   csrcbs_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   csrcbs_back #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .n_active         (n_active),
      .q_stat           (q_stat),
      .head             (head),
      .pop              (pop),
      .idle             (back_idle),
      .rd_idx           (rd_idx),
      .rd_start         (rd_start),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_block_out    (rsp_block_out),
      .rsp_local_column (rsp_local_column),
      .rsp_position     (rsp_position),
      .rsp_value_out    (rsp_value_out),
      .rsp_row_number   (rsp_row_number),
      .rsp_last         (rsp_last)
   );

endmodule
